@@ hdl/traffic_phase_sequencer_core_defines.svh @@
// assertion macros shared by the phase sequencer rtl
// depends on nothing; users supply clock and reset named clock and reset
`ifndef TRAFFIC_PHASE_SEQUENCER_CORE_DEFINES_SVH
`define TRAFFIC_PHASE_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TPS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define TPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/tps_pkg.sv @@
// types, phase codes and class table for the traffic phase sequencer
// no dependencies
package tps_pkg;

   typedef logic [4:0] phase_type;
   typedef logic [1:0] class_type;
   typedef logic [4:0] latch_type;

   localparam phase_type PH_00 = 5'd0;   // all red, north-south side
   localparam phase_type PH_01 = 5'd1;   // north-south green
   localparam phase_type PH_02 = 5'd2;
   localparam phase_type PH_03 = 5'd3;
   localparam phase_type PH_04 = 5'd4;
   localparam phase_type PH_05 = 5'd5;
   localparam phase_type PH_06 = 5'd6;
   localparam phase_type PH_07 = 5'd7;
   localparam phase_type PH_08 = 5'd8;
   localparam phase_type PH_09 = 5'd9;
   localparam phase_type PH_10 = 5'd10;
   localparam phase_type PH_11 = 5'd11;  // all red, east-west side
   localparam phase_type PH_12 = 5'd12;
   localparam phase_type PH_13 = 5'd13;
   localparam phase_type PH_14 = 5'd14;
   localparam phase_type PH_15 = 5'd15;
   localparam phase_type PH_16 = 5'd16;
   localparam phase_type PH_17 = 5'd17;
   localparam phase_type PH_18 = 5'd18;
   localparam phase_type PH_19 = 5'd19;

   localparam class_type CLS_RED  = 2'd0;
   localparam class_type CLS_STRT = 2'd1;
   localparam class_type CLS_TURN = 2'd2;
   localparam class_type CLS_YEL  = 2'd3;

   // request latch bit positions
   localparam int LAT_NE = 0;
   localparam int LAT_SW = 1;
   localparam int LAT_ES = 2;
   localparam int LAT_WN = 3;
   localparam int LAT_EW = 4;

   // one request beat, ne in the lowest bit
   typedef struct packed {
      logic locked;
      logic train_present;
      logic ew_request;
      logic wn_request;
      logic es_request;
      logic sw_request;
      logic ne_request;
   } item_type;

   // decision handed from the next-phase logic to the top level
   typedef struct packed {
      phase_type next_phase;
      latch_type latch_clear;
   } decision_type;

   function automatic class_type class_of(phase_type p);
      class_type c;
      case (p) inside
         PH_00, PH_11:                             c = CLS_RED;
         PH_01, PH_03:                             c = CLS_STRT;
         PH_05, PH_07, PH_09, PH_12, PH_14, PH_16: c = CLS_TURN;
         PH_02, PH_04, PH_06, PH_08, PH_10, PH_13,
         PH_15, PH_17, PH_18, PH_19:               c = CLS_YEL;
         default:                                  c = CLS_RED;
      endcase
      return c;
   endfunction

endpackage

@@ hdl/traffic_phase_sequencer_core.sv @@
// traffic phase sequencer, top level: request register, next-phase logic, result register
// depends on tps_pkg, tps_next_phase and traffic_phase_sequencer_core_defines.svh
// a request beat goes to the request register, then to the result register once that is free
// throughput: one beat per cycle while rsp_tready is high; phase and latches feed u_next
// reset: synchronous, active high; phase 0 (all red), latches clear, peak mode on, pipe empty
// csr writes are taken every cycle and are meant to land only while the pipe is empty
`include "traffic_phase_sequencer_core_defines.svh"

module traffic_phase_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // ne, sw, es, wn, ew, train_present, locked, pad
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // ended_phase[4:0], timing_class[6:5], next_phase[11:7], pad
   // config write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // peak_mode
);
   import tps_pkg::*;

   // control registers
   logic         req_valid_ff, req_valid_in;
   logic         rsp_valid_ff, rsp_valid_in;
   phase_type    phase_ff, phase_in;
   latch_type    latches_ff, latches_in;
   logic         peak_ff, peak_in;

   // payload registers
   item_type     req_item_ff;
   phase_type    rsp_ended_ff;
   class_type    rsp_class_ff;
   phase_type    rsp_next_ff;

   logic         req_take;     // request beat accepted
   logic         advance;      // result register free for a new beat
   logic         load;         // request register moves into the result register
   latch_type    merged;       // latches with the new requests ORed in
   decision_type decision;

   assign csr_ready  = 1'b1;
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !req_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign load       = req_valid_ff && advance;

   assign merged = latches_ff | {req_item_ff.ew_request, req_item_ff.wn_request,
                                 req_item_ff.es_request, req_item_ff.sw_request,
                                 req_item_ff.ne_request};

   tps_next_phase u_next (
      .phase    (phase_ff),
      .latches  (merged),
      .train    (req_item_ff.train_present),
      .lock     (req_item_ff.locked),
      .peak     (peak_ff),
      .decision (decision)
   );

   always_comb begin
      req_valid_in = req_take ? 1'b1 : (load ? 1'b0 : req_valid_ff);
      rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      // phase and latches step only when a beat is handed to the result register
      phase_in     = load ? decision.next_phase : phase_ff;
      latches_in   = load ? (merged & ~decision.latch_clear) : latches_ff;
      peak_in      = (csr_valid && csr_ready) ? csr_data : peak_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_00;
         latches_ff   <= '0;
         peak_ff      <= 1'b1;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         latches_ff   <= latches_in;
         peak_ff      <= peak_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff <= item_type'(req_tdata[6:0]);
      end
      if (load) begin
         rsp_ended_ff <= phase_ff;
         rsp_class_ff <= class_of(phase_ff);
         rsp_next_ff  <= decision.next_phase;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_next_ff, rsp_class_ff, rsp_ended_ff};

   // the phase register always matches the next phase of the beat on display
   `TPS_ASSERT_SAME(a_phase_tracks_rsp, rsp_valid_ff, phase_ff == rsp_next_ff,
      "phase register differs from next phase of pending result")
   // phases stay within the table
   `TPS_ASSERT_SAME(a_phase_range, 1'b1, phase_ff <= PH_19,
      "phase register out of range")
   // lock never lets the east-west all red be entered
   `TPS_ASSERT_NEXT(a_lock_redirect, load && req_item_ff.locked, phase_ff != PH_11,
      "east-west all red entered while locked")
   // leaving the north-south all red consumes the ne and sw latches
   `TPS_ASSERT_NEXT(a_ns_latch_clear, load && phase_ff == PH_00,
      !latches_ff[LAT_NE] && !latches_ff[LAT_SW],
      "ne or sw latch survived leaving phase 0")

endmodule

@@ hdl/tps_next_phase.sv @@
// next-phase selection and latch consumption for one phase end
// depends on tps_pkg
module tps_next_phase (
   input  tps_pkg::phase_type    phase,
   input  tps_pkg::latch_type    latches,
   input  logic                  train,
   input  logic                  lock,
   input  logic                  peak,
   output tps_pkg::decision_type decision
);
   import tps_pkg::*;

   logic      ne, sw, es, wn, ew;
   phase_type nx;
   latch_type clr;

   assign ne = latches[LAT_NE];
   assign sw = latches[LAT_SW];
   assign es = latches[LAT_ES];
   assign wn = latches[LAT_WN];
   assign ew = latches[LAT_EW];

   always_comb begin
      nx  = phase;
      clr = '0;
      case (phase)
         PH_00: begin
            if (lock)              nx = PH_01;
            else if (train)        nx = PH_11;
            else if (!ne && !sw)   nx = PH_01;
            else if (!ne && sw)    nx = PH_09;
            else if (ne && !sw)    nx = PH_05;
            else                   nx = PH_07;
            clr[LAT_NE] = 1'b1;
            clr[LAT_SW] = 1'b1;
         end
         PH_01: begin
            if (lock)                         nx = PH_01;
            else if (peak || ew || es || wn)  nx = PH_02;
            else                              nx = PH_01;
         end
         PH_02: nx = PH_11;
         PH_03: nx = train ? PH_03 : PH_04;
         PH_04: nx = PH_00;
         PH_05: nx = train ? PH_18 : PH_06;
         PH_06: nx = train ? PH_18 : PH_01;
         PH_07: nx = PH_08;
         PH_08: nx = train ? PH_11 : PH_01;
         PH_09: nx = train ? PH_19 : PH_10;
         PH_10: nx = train ? PH_19 : PH_01;
         PH_11: begin
            if (train) begin
               if (peak) nx = (!es && wn) ? PH_16 : PH_03;
               else      nx = (es && !wn) ? PH_12 : PH_03;
            end else if (!es && !wn) nx = PH_03;
            else if (!es && wn)      nx = PH_16;
            else if (es && !wn)      nx = PH_12;
            else                     nx = PH_14;
            clr[LAT_ES] = 1'b1;
            clr[LAT_WN] = 1'b1;
            clr[LAT_EW] = !peak;
         end
         PH_12: nx = PH_13;
         PH_14: nx = PH_15;
         PH_16: nx = PH_17;
         PH_13, PH_15, PH_17: nx = PH_03;
         PH_18, PH_19: nx = PH_11;
         default: nx = phase;
      endcase
      // lock turns a move into the east-west all red back to the north-south all red
      if (lock && nx == PH_11) nx = PH_00;
      decision.next_phase  = nx;
      decision.latch_clear = clr;
   end

endmodule
